/* hw/rtl/sesp_pkg.sv */
// ----------------------------------------------------------------------------
// Structural similarity edge prune: shared package
// Widths, codes and item types used across the edge prune block.
// ----------------------------------------------------------------------------
package sesp_pkg;

	localparam int DEG_BITS   = 20;
	localparam int EPS_W      = 16;
	localparam int MIN_W      = DEG_BITS;
	localparam int SD_W       = DEG_BITS + 1;
	localparam int ED_W       = DEG_BITS + 2;
	localparam int MUL_W      = (DEG_BITS > EPS_W) ? DEG_BITS : EPS_W;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int TEST_W     = DEG_BITS + EPS_W;
	localparam int P_W        = 2 * DEG_BITS + EPS_W;
	localparam int TRIAL_W    = P_W + 2;
	localparam int SQ_W       = EPS_W + 2 * (DEG_BITS - 1);
	localparam int ITER_W     = $clog2(DEG_BITS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = (MIN_W > EPS_W) ? MIN_W : EPS_W;

	localparam logic [DEG_BITS-1:0] SIMILAR_LIMIT = DEG_BITS'(2);

	localparam logic [EPS_W-1:0] EPS_NUM_RST = EPS_W'(1);
	localparam logic [EPS_W-1:0] EPS_DEN_RST = EPS_W'(4);
	localparam logic [MIN_W-1:0] MIN_SIM_RST = MIN_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EPS_NUM     = 2'd0,
		CFG_EPS_DEN     = 2'd1,
		CFG_MIN_SIMILAR = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CLS_NOT_SIMILAR = 2'd0,
		CLS_SIMILAR     = 2'd1,
		CLS_UNDECIDED   = 2'd2
	} edge_class_t;

	typedef enum logic [1:0] {
		VS_UNKNOWN  = 2'd0,
		VS_CORE     = 2'd1,
		VS_NON_CORE = 2'd2
	} vertex_status_t;

	typedef enum logic [2:0] {
		MUL_IDLE  = 3'd0,
		MUL_A_B2  = 3'd1,
		MUL_B_A2  = 3'd2,
		MUL_A_B   = 3'd3,
		MUL_LO_A2 = 3'd4,
		MUL_HI_A2 = 3'd5,
		MUL_SUM   = 3'd6
	} mul_op_t;

	typedef struct packed {
		logic        accept;
		logic        update;
		edge_class_t cls;
		logic        last;
	} stats_ctl_t;

	typedef struct packed {
		logic [DEG_BITS-1:0] deg_self;
		logic [DEG_BITS-1:0] deg_neighbour;
		logic                last_edge;
	} edge_item_t;

	typedef struct packed {
		edge_class_t         edge_class;
		logic [DEG_BITS-1:0] cn_bound;
		logic                last_out;
		vertex_status_t      vertex_status;
	} res_item_t;

endpackage

/* hw/rtl/structural_similarity_edge_prune_core.sv */
// ----------------------------------------------------------------------------
// Structural similarity edge prune core
// Classes each streamed edge against the epsilon-squared degree bound, gives
// the exact common-neighbour lower bound, and reports vertex core status.
//
//   channel   handshake               payload        direction
//   edge      edge_valid/edge_ready   edge_item      in
//   res       res_valid/res_ready     res_item       out
//   cfg       cfg_we                  cfg_idx/wdata  in
//
// An item goes through six steps on the shared multiplier. When the degree
// test passes, the ceiling root unit then gives one result bit per cycle
// (DEG_BITS bits in all), and a final step loads the result register.
// One item at a time; edge_ready is high only while idle.
// The result register frees the core: a new item is taken while a result waits.
// A stalled result holds the core in its final step until res_ready.
// Reset (arst_n low) restores the register defaults and opens a new vertex.
// ----------------------------------------------------------------------------
module structural_similarity_edge_prune_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            edge_valid,
	output logic                            edge_ready,
	input  sesp_pkg::edge_item_t            edge_item,
	output logic                            res_valid,
	input  logic                            res_ready,
	output sesp_pkg::res_item_t             res_item,
	input  logic                            cfg_we,
	input  logic [sesp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sesp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_AB2  = 9'b000000010,
		ST_BA2  = 9'b000000100,
		ST_AB   = 9'b000001000,
		ST_LO   = 9'b000010000,
		ST_HI   = 9'b000100000,
		ST_SUM  = 9'b001000000,
		ST_ROOT = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t                          state_q;
	state_t                          state_d;
	sesp_pkg::mul_op_t               op;
	logic [sesp_pkg::EPS_W-1:0]      eps_num_q;
	logic [sesp_pkg::EPS_W-1:0]      eps_den_q;
	logic [sesp_pkg::MIN_W-1:0]      min_sim_q;
	logic [sesp_pkg::DEG_BITS-1:0]   a_q;
	logic [sesp_pkg::DEG_BITS-1:0]   b_q;
	logic                            last_q;
	logic                            accept;
	logic                            finish;
	logic                            not_sim;
	logic [sesp_pkg::P_W-1:0]        p;
	logic                            root_start;
	logic                            root_busy;
	logic [sesp_pkg::DEG_BITS-1:0]   c;
	sesp_pkg::edge_class_t           cls;
	sesp_pkg::vertex_status_t        status;
	sesp_pkg::stats_ctl_t            stats_ctl;
	logic                            res_valid_q;
	sesp_pkg::res_item_t             res_item_q;

	assign edge_ready = (state_q == ST_IDLE);
	assign accept     = edge_valid && edge_ready;
	assign finish     = (state_q == ST_DONE) && (!res_valid_q || res_ready);
	assign root_start = (state_q == ST_SUM) && !not_sim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_num_q <= sesp_pkg::EPS_NUM_RST;
			eps_den_q <= sesp_pkg::EPS_DEN_RST;
			min_sim_q <= sesp_pkg::MIN_SIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sesp_pkg::CFG_EPS_NUM: eps_num_q <= cfg_wdata[sesp_pkg::EPS_W-1:0];
				sesp_pkg::CFG_EPS_DEN: eps_den_q <= cfg_wdata[sesp_pkg::EPS_W-1:0];
				sesp_pkg::CFG_MIN_SIMILAR: min_sim_q <= cfg_wdata[sesp_pkg::MIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		op      = sesp_pkg::MUL_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_AB2;
				end
			end
			ST_AB2: begin
				op      = sesp_pkg::MUL_A_B2;
				state_d = ST_BA2;
			end
			ST_BA2: begin
				op      = sesp_pkg::MUL_B_A2;
				state_d = ST_AB;
			end
			ST_AB: begin
				op      = sesp_pkg::MUL_A_B;
				state_d = ST_LO;
			end
			ST_LO: begin
				op      = sesp_pkg::MUL_LO_A2;
				state_d = ST_HI;
			end
			ST_HI: begin
				op      = sesp_pkg::MUL_HI_A2;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				op      = sesp_pkg::MUL_SUM;
				state_d = not_sim ? ST_DONE : ST_ROOT;
			end
			ST_ROOT: begin
				if (!root_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (edge_item.deg_self < edge_item.deg_neighbour) begin
				a_q <= edge_item.deg_self;
				b_q <= edge_item.deg_neighbour;
			end else begin
				a_q <= edge_item.deg_neighbour;
				b_q <= edge_item.deg_self;
			end
			last_q <= edge_item.last_edge;
		end
	end

	sesp_mul u_mul (
		.clk     (clk),
		.op      (op),
		.a       (a_q),
		.b       (b_q),
		.eps_num (eps_num_q),
		.eps_den (eps_den_q),
		.not_sim (not_sim),
		.p       (p)
	);

	sesp_root u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.eps_den (eps_den_q),
		.p       (p),
		.busy    (root_busy),
		.c       (c)
	);

	always_comb begin
		priority if (not_sim) begin
			cls = sesp_pkg::CLS_NOT_SIMILAR;
		end else if (c <= sesp_pkg::SIMILAR_LIMIT) begin
			cls = sesp_pkg::CLS_SIMILAR;
		end else begin
			cls = sesp_pkg::CLS_UNDECIDED;
		end
	end

	assign stats_ctl.accept = accept;
	assign stats_ctl.update = finish;
	assign stats_ctl.cls    = cls;
	assign stats_ctl.last   = last_q;

	sesp_stats u_stats (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (stats_ctl),
		.deg_self    (edge_item.deg_self),
		.min_similar (min_sim_q),
		.status      (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_item_q.edge_class    <= cls;
			res_item_q.cn_bound      <= (cls == sesp_pkg::CLS_UNDECIDED) ? c : '0;
			res_item_q.last_out      <= last_q;
			res_item_q.vertex_status <= status;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

/* hw/rtl/sesp_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// One registered multiplier stepped through the degree products, the
// similarity test compare and assembly of the a*b*a2 target.
// ----------------------------------------------------------------------------
module sesp_mul (
	input  logic                         clk,
	input  sesp_pkg::mul_op_t            op,
	input  logic [sesp_pkg::DEG_BITS-1:0] a,
	input  logic [sesp_pkg::DEG_BITS-1:0] b,
	input  logic [sesp_pkg::EPS_W-1:0]    eps_num,
	input  logic [sesp_pkg::EPS_W-1:0]    eps_den,
	output logic                         not_sim,
	output logic [sesp_pkg::P_W-1:0]      p
);

	logic [sesp_pkg::MUL_W-1:0]    x;
	logic [sesp_pkg::MUL_W-1:0]    y;
	logic [sesp_pkg::PROD_W-1:0]   prod_d;
	logic [sesp_pkg::PROD_W-1:0]   prod_q;
	logic [sesp_pkg::TEST_W-1:0]   part_q;
	logic [sesp_pkg::DEG_BITS-1:0] hi_q;
	logic                          not_sim_q;
	logic [sesp_pkg::P_W-1:0]      p_q;

	always_comb begin
		unique case (op)
			sesp_pkg::MUL_A_B2: begin
				x = sesp_pkg::MUL_W'(a);
				y = sesp_pkg::MUL_W'(eps_den);
			end
			sesp_pkg::MUL_B_A2: begin
				x = sesp_pkg::MUL_W'(b);
				y = sesp_pkg::MUL_W'(eps_num);
			end
			sesp_pkg::MUL_A_B: begin
				x = sesp_pkg::MUL_W'(a);
				y = sesp_pkg::MUL_W'(b);
			end
			sesp_pkg::MUL_LO_A2: begin
				x = sesp_pkg::MUL_W'(prod_q[sesp_pkg::DEG_BITS-1:0]);
				y = sesp_pkg::MUL_W'(eps_num);
			end
			sesp_pkg::MUL_HI_A2: begin
				x = sesp_pkg::MUL_W'(hi_q);
				y = sesp_pkg::MUL_W'(eps_num);
			end
			default: begin
				x = '0;
				y = '0;
			end
		endcase
	end

	assign prod_d = {{sesp_pkg::MUL_W{1'b0}}, x} * {{sesp_pkg::MUL_W{1'b0}}, y};

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		unique case (op)
			sesp_pkg::MUL_B_A2: begin
				part_q <= prod_q[sesp_pkg::TEST_W-1:0];
			end
			sesp_pkg::MUL_A_B: begin
				not_sim_q <= part_q < prod_q[sesp_pkg::TEST_W-1:0];
			end
			sesp_pkg::MUL_LO_A2: begin
				hi_q <= prod_q[2*sesp_pkg::DEG_BITS-1:sesp_pkg::DEG_BITS];
			end
			sesp_pkg::MUL_HI_A2: begin
				part_q <= prod_q[sesp_pkg::TEST_W-1:0];
			end
			sesp_pkg::MUL_SUM: begin
				p_q <= sesp_pkg::P_W'(part_q)
					+ (sesp_pkg::P_W'(prod_q[sesp_pkg::TEST_W-1:0]) << sesp_pkg::DEG_BITS);
			end
			default: begin
			end
		endcase
	end

	assign not_sim = not_sim_q;
	assign p       = p_q;

endmodule

/* hw/rtl/sesp_root.sv */
// ----------------------------------------------------------------------------
// Ceiling root unit
// Bit-serial search for the least c with c*c*b2 >= p, one result bit per
// cycle from the top, using running square and cross terms (no multiplier).
// ----------------------------------------------------------------------------
module sesp_root (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sesp_pkg::EPS_W-1:0]    eps_den,
	input  logic [sesp_pkg::P_W-1:0]      p,
	output logic                          busy,
	output logic [sesp_pkg::DEG_BITS-1:0] c
);

	logic                          busy_q;
	logic [sesp_pkg::ITER_W-1:0]   k_q;
	logic [sesp_pkg::P_W-1:0]      s_q;
	logic [sesp_pkg::P_W-1:0]      lin_q;
	logic [sesp_pkg::SQ_W-1:0]     sq_q;
	logic [sesp_pkg::DEG_BITS-1:0] c_q;
	logic [sesp_pkg::TRIAL_W-1:0]  trial;
	logic                          take;

	// trial = (c + 2^k)^2 * b2
	assign trial = sesp_pkg::TRIAL_W'(s_q) + sesp_pkg::TRIAL_W'(lin_q)
		+ sesp_pkg::TRIAL_W'(sq_q);
	assign take  = trial < sesp_pkg::TRIAL_W'(p);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && k_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q   <= sesp_pkg::ITER_W'(sesp_pkg::DEG_BITS - 1);
			s_q   <= '0;
			lin_q <= '0;
			sq_q  <= sesp_pkg::SQ_W'(eps_den) << (2 * (sesp_pkg::DEG_BITS - 1));
			c_q   <= '0;
		end else if (busy_q) begin
			k_q   <= k_q - sesp_pkg::ITER_W'(1);
			if (take) begin
				s_q   <= trial[sesp_pkg::P_W-1:0];
				lin_q <= (lin_q >> 1) + sesp_pkg::P_W'(sq_q);
			end else begin
				lin_q <= lin_q >> 1;
			end
			sq_q  <= sq_q >> 2;
			c_q   <= {c_q[sesp_pkg::DEG_BITS-2:0], take};
		end
	end

	assign busy = busy_q;
	assign c    = (p == '0) ? '0 : c_q + sesp_pkg::DEG_BITS'(1);

endmodule

/* hw/rtl/sesp_stats.sv */
// ----------------------------------------------------------------------------
// Vertex statistics
// Similar count and possible-similar count over one adjacency list, and the
// core decision on the list's last edge.
// ----------------------------------------------------------------------------
module sesp_stats (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sesp_pkg::stats_ctl_t          ctl,
	input  logic [sesp_pkg::DEG_BITS-1:0] deg_self,
	input  logic [sesp_pkg::MIN_W-1:0]    min_similar,
	output sesp_pkg::vertex_status_t      status
);

	localparam logic [sesp_pkg::ED_W-1:0] ED_MIN = {1'b1, {(sesp_pkg::ED_W-1){1'b0}}};

	logic                        first_q;
	logic [sesp_pkg::SD_W-1:0]   sd_q;
	logic [sesp_pkg::ED_W-1:0]   ed_q;
	logic [sesp_pkg::SD_W-1:0]   sd_nx;
	logic [sesp_pkg::ED_W-1:0]   ed_nx;

	always_comb begin
		sd_nx = sd_q;
		ed_nx = ed_q;
		if (ctl.cls == sesp_pkg::CLS_SIMILAR && sd_q != '1) begin
			sd_nx = sd_q + sesp_pkg::SD_W'(1);
		end
		if (ctl.cls == sesp_pkg::CLS_NOT_SIMILAR && ed_q != ED_MIN) begin
			ed_nx = ed_q - sesp_pkg::ED_W'(1);
		end
	end

	always_comb begin
		priority if (!ctl.last) begin
			status = sesp_pkg::VS_UNKNOWN;
		end else if (sd_nx >= sesp_pkg::SD_W'(min_similar)) begin
			status = sesp_pkg::VS_CORE;
		end else if (ed_nx[sesp_pkg::ED_W-1]
			|| ed_nx[sesp_pkg::ED_W-2:0] < (sesp_pkg::ED_W-1)'(min_similar)) begin
			status = sesp_pkg::VS_NON_CORE;
		end else begin
			status = sesp_pkg::VS_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			sd_q    <= '0;
			ed_q    <= '0;
		end else if (ctl.accept && first_q) begin
			sd_q <= '0;
			ed_q <= sesp_pkg::ED_W'(deg_self) - sesp_pkg::ED_W'(1);
		end else if (ctl.update) begin
			first_q <= ctl.last;
			sd_q    <= sd_nx;
			ed_q    <= ed_nx;
		end
	end

endmodule

/* hw/rtl/sesp_checker.sv */
// ----------------------------------------------------------------------------
// Edge prune port checker
// Port-level checks on the edge prune core, bound to the top level.
// ----------------------------------------------------------------------------
module sesp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                edge_valid,
	input logic                edge_ready,
	input logic                res_valid,
	input logic                res_ready,
	input sesp_pkg::res_item_t res_item
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result item dropped or changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		edge_valid && edge_ready |=> !edge_ready)
		else $error("edge_ready stayed high after an accepted item");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!edge_ready))
		else $error("result appeared without an item in progress");

	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.last_out |-> res_item.vertex_status == sesp_pkg::VS_UNKNOWN)
		else $error("vertex status set on an edge that is not last");

	a_bound_matches_class: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
			(res_item.edge_class == sesp_pkg::CLS_UNDECIDED
				&& res_item.cn_bound > sesp_pkg::SIMILAR_LIMIT)
			|| (res_item.edge_class != sesp_pkg::CLS_UNDECIDED && res_item.cn_bound == '0))
		else $error("common-neighbour bound does not match edge class");

endmodule

bind structural_similarity_edge_prune_core sesp_checker u_sesp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.edge_valid (edge_valid),
	.edge_ready (edge_ready),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.res_item   (res_item)
);

/* verif/tb_structural_similarity_edge_prune_core.sv */
// ----------------------------------------------------------------------------
// Structural similarity edge prune core testbench
// Streams vertex adjacency lists through the core under several threshold
// settings. Each accepted edge is run through a local model of the degree
// test, the exact common-neighbour bound and the vertex core status. Every
// result is checked field by field against it, with random idle bursts on
// both handshakes in every phase but the last.
// ----------------------------------------------------------------------------
module tb_structural_similarity_edge_prune_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sesp_pkg::*;

	localparam logic [DEG_BITS-1:0] DEG_TOP = '1;
	localparam int SD_MAX       = (1 << SD_W) - 1;
	localparam int ED_MIN       = -(1 << (ED_W - 1));
	localparam int QUIET_LIMIT  = 4000;
	localparam int ERR_PRINT    = 40;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  edge_valid = 1'b0;
	logic                  edge_ready;
	edge_item_t            edge_item  = '0;
	logic                  res_valid;
	logic                  res_ready  = 1'b0;
	res_item_t             res_item;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx    = CFG_EPS_NUM;
	logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

	// threshold registers and per-vertex counts as the core should hold them
	longint unsigned eps_num_q   = EPS_NUM_RST;
	longint unsigned eps_den_q   = EPS_DEN_RST;
	int unsigned     min_sim_q   = MIN_SIM_RST;
	int              similar_cnt  = 0;
	int              possible_cnt = 0;
	bit              opens_vertex = 1'b1;

	edge_item_t edge_backlog[$];
	res_item_t  predicted_results[$];

	bit idle_on = 1'b1;
	int send_gap = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int edges_queued = 0;
	int edges_sent = 0;
	int results_checked = 0;
	int class_seen[3];
	int status_seen[3];

	structural_similarity_edge_prune_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_valid (edge_valid),
		.edge_ready (edge_ready),
		.edge_item  (edge_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic res_item_t classify_edge(input edge_item_t e);
		longint unsigned lo_deg, hi_deg, target, lo, hi, mid;
		res_item_t r;
		lo_deg = (e.deg_self < e.deg_neighbour) ? e.deg_self : e.deg_neighbour;
		hi_deg = (e.deg_self < e.deg_neighbour) ? e.deg_neighbour : e.deg_self;
		r.edge_class    = CLS_NOT_SIMILAR;
		r.cn_bound      = '0;
		r.last_out      = e.last_edge;
		r.vertex_status = VS_UNKNOWN;
		if (opens_vertex) begin
			similar_cnt  = 0;
			// deg_self - 1 stays within the signed ED_W range for 20-bit degrees
			possible_cnt = int'(e.deg_self) - 1;
		end
		if (lo_deg * eps_den_q < hi_deg * eps_num_q) begin
			if (possible_cnt > ED_MIN)
				possible_cnt--;
		end else begin
			// least c in [0, a] with c*c*b2 >= a*b*a2
			target = lo_deg * hi_deg * eps_num_q;
			lo = 0;
			hi = lo_deg;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (mid * mid * eps_den_q >= target)
					hi = mid;
				else
					lo = mid + 1;
			end
			if (lo <= longint'(SIMILAR_LIMIT)) begin
				r.edge_class = CLS_SIMILAR;
				if (similar_cnt < SD_MAX)
					similar_cnt++;
			end else begin
				r.edge_class = CLS_UNDECIDED;
				r.cn_bound   = DEG_BITS'(lo);
			end
		end
		if (e.last_edge) begin
			if (similar_cnt >= int'(min_sim_q))
				r.vertex_status = VS_CORE;
			else if (possible_cnt < int'(min_sim_q))
				r.vertex_status = VS_NON_CORE;
		end
		opens_vertex = e.last_edge;
		return r;
	endfunction

	task automatic report_error(input string msg);
		if (error_count < ERR_PRINT)
			$display("tb: mismatch at result %0d: %s", results_checked, msg);
		error_count++;
	endtask

	task automatic check_result(input res_item_t got);
		res_item_t want;
		if (predicted_results.size() == 0) begin
			report_error("result with no edge outstanding");
			return;
		end
		want = predicted_results.pop_front();
		if (got.edge_class !== want.edge_class)
			report_error($sformatf("edge_class %0d, want %0d", got.edge_class, want.edge_class));
		if (got.cn_bound !== want.cn_bound)
			report_error($sformatf("cn_bound %0d, want %0d", got.cn_bound, want.cn_bound));
		if (got.last_out !== want.last_out)
			report_error($sformatf("last_out %0d, want %0d", got.last_out, want.last_out));
		if (got.vertex_status !== want.vertex_status)
			report_error($sformatf("vertex_status %0d, want %0d",
				got.vertex_status, want.vertex_status));
		class_seen[int'(want.edge_class)]++;
		if (want.last_out)
			status_seen[int'(want.vertex_status)]++;
		results_checked++;
	endtask

	// edge driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_valid <= 1'b0;
			send_gap   <= 0;
		end else begin
			if (edge_valid && edge_ready) begin
				predicted_results.push_back(classify_edge(edge_item));
				edges_sent++;
			end
			if (edge_valid && !edge_ready) begin
				// hold the item until taken
			end else if (send_gap != 0) begin
				send_gap   <= send_gap - 1;
				edge_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				send_gap   <= $urandom_range(0, 10);
				edge_valid <= 1'b0;
			end else if (edge_backlog.size() != 0) begin
				edge_item  <= edge_backlog.pop_front();
				edge_valid <= 1'b1;
			end else begin
				edge_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_valid && res_ready)
				check_result(res_item);
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				res_ready  <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 10);
				res_ready  <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((edge_valid && edge_ready) || (res_valid && res_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("tb: no handshake for %0d cycles", QUIET_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic queue_edge(input int unsigned ds, input int unsigned dn, input bit last);
		edge_item_t e;
		e.deg_self      = DEG_BITS'(ds);
		e.deg_neighbour = DEG_BITS'(dn);
		e.last_edge     = last;
		edge_backlog.push_back(e);
		edges_queued++;
	endtask

	function automatic int unsigned pick_degree();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return $urandom_range(1, 16);
		else if (roll < 85)
			return $urandom_range(17, 4096);
		else if (roll < 97)
			return $urandom_range(0, int'(DEG_TOP));
		return 0;
	endfunction

	task automatic queue_random_vertex();
		int unsigned self_deg;
		int n;
		self_deg = pick_degree();
		if (self_deg == 0)
			n = 1;
		else if (self_deg <= 12)
			n = self_deg;
		else
			n = $urandom_range(1, 12);
		for (int k = 0; k < n; k++)
			queue_edge(self_deg, pick_degree(), k == n - 1);
	endtask

	task automatic queue_broken_list();
		int n;
		n = $urandom_range(1, 6);
		for (int k = 0; k < n; k++)
			queue_edge(pick_degree(), pick_degree(), $urandom_range(0, 3) == 0);
	endtask

	task automatic random_phase(input int count);
		int stop;
		int roll;
		stop = edges_queued + count;
		while (edges_queued < stop) begin
			roll = $urandom_range(0, 99);
			if (roll < 85)
				queue_random_vertex();
			else if (roll < 95)
				queue_broken_list();
			else
				queue_edge($urandom_range(0, int'(DEG_TOP)), $urandom_range(0, int'(DEG_TOP)),
					$urandom_range(0, 1));
		end
	endtask

	task automatic drain();
		while (results_checked != edges_queued)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom_range(0, 15)) << EPS_W;
		@(posedge clk);
		cfg_we  <= 1'b1;
		cfg_idx <= idx;
		case (idx)
			CFG_EPS_NUM: begin
				cfg_wdata <= CFG_DATA_W'(value[EPS_W-1:0]) | junk;
				eps_num_q = value[EPS_W-1:0];
			end
			CFG_EPS_DEN: begin
				cfg_wdata <= CFG_DATA_W'(value[EPS_W-1:0]) | junk;
				eps_den_q = value[EPS_W-1:0];
			end
			default: begin
				cfg_wdata <= CFG_DATA_W'(value);
				min_sim_q = value[MIN_W-1:0];
			end
		endcase
	endtask

	task automatic set_thresholds(input int unsigned num, input int unsigned den,
			input int unsigned min_sim);
		write_reg(CFG_EPS_NUM, num);
		write_reg(CFG_EPS_DEN, den);
		write_reg(CFG_MIN_SIMILAR, min_sim);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned den;
		int unsigned num;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset thresholds: extremes, zero degrees, mixed outcomes
		queue_edge(DEG_TOP, DEG_TOP, 0);
		queue_edge(DEG_TOP, 1, 0);
		queue_edge(1, DEG_TOP, 0);
		queue_edge(3, 4, 0);
		queue_edge(7, 7, 1);
		queue_edge(0, 0, 1);
		queue_edge(0, DEG_TOP, 1);
		queue_edge(2, 2, 0);
		queue_edge(2, 2, 1);
		queue_edge(5, 100, 0);
		queue_edge(5, 5, 0);
		queue_edge(5, 5, 1);
		drain();

		// zero numerator: everything similar
		set_thresholds(0, 65535, int'(DEG_TOP));
		queue_edge(DEG_TOP, DEG_TOP, 0);
		queue_edge(1, 1, 1);
		drain();

		// zero denominator, zero min_similar
		set_thresholds(65535, 0, 0);
		queue_edge(0, 0, 0);
		queue_edge(5, 3, 1);
		drain();

		// numerator above denominator
		set_thresholds(65535, 1, 1);
		queue_edge(100, 100, 0);
		queue_edge(0, 0, 1);
		drain();

		// epsilon of one
		set_thresholds(65535, 65535, 1);
		queue_edge(3, 3, 0);
		queue_edge(9, 9, 1);
		drain();

		set_thresholds(1, 2, 3);
		random_phase(225);
		drain();

		set_thresholds(9, 16, 1);
		random_phase(225);
		drain();

		den = $urandom_range(1, 65535);
		set_thresholds($urandom_range(0, den), den, $urandom_range(1, 6));
		random_phase(225);
		drain();

		set_thresholds(65535, 65535, int'(DEG_TOP));
		random_phase(225);
		drain();

		num = $urandom_range(1, 100);
		set_thresholds(num, num + $urandom_range(0, 400), $urandom_range(0, 5));
		random_phase(225);
		drain();

		idle_on = 1'b0;
		set_thresholds(EPS_NUM_RST, EPS_DEN_RST, MIN_SIM_RST);
		random_phase(225);
		drain();
		repeat (40) @(posedge clk);

		$display("tb: %0d edges sent, %0d results checked; not similar %0d, similar %0d, undecided %0d",
			edges_sent, results_checked, class_seen[0], class_seen[1], class_seen[2]);
		$display("tb: vertices closed as unknown %0d, core %0d, non-core %0d",
			status_seen[0], status_seen[1], status_seen[2]);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
